>>> rtl/core/ptg_pkg.sv
// Shared constants, types and helper functions of the probabilistic table gate.
// Used by the channel interfaces and by every module of the block but ptg_ram.
// Depends on nothing.
package ptg_pkg;

    localparam int MAX_IN_BITS  = 4;
    localparam int MAX_OUT_BITS = 4;
    localparam int ROWS         = 1 << MAX_IN_BITS;
    localparam int COLS         = 1 << MAX_OUT_BITS;
    localparam int ADDR_W       = MAX_IN_BITS + MAX_OUT_BITS;
    localparam int ENTRIES      = ROWS * COLS;
    localparam int WEIGHT_W     = 8;
    localparam int SUM_W        = WEIGHT_W + MAX_OUT_BITS;
    localparam int WIDTH_REG_W  = 3;
    localparam int RND_W        = 31;
    localparam int CNT_W        = $clog2(RND_W);
    localparam int CFG_IDX_W    = 1;

    localparam logic CMD_EVAL  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH = 1'd1;

    // Operands and result of the shared subtractor.
    typedef struct packed {
        logic [SUM_W:0]   a;
        logic [SUM_W-1:0] b;
    } sub_req_t;

    typedef struct packed {
        logic [SUM_W:0] diff;
        logic           borrow;
    } sub_rsp_t;

    // A width of zero acts as one, and widths above the maximum saturate.
    function automatic logic [MAX_IN_BITS-1:0] in_mask(input logic [WIDTH_REG_W-1:0] w);
        logic [MAX_IN_BITS-1:0] m;
        m = '0;
        for (int i = 0; i < MAX_IN_BITS; i++)
        begin
            if ((i == 0) || (i < int'(w)))
            begin
                m[i] = 1'b1;
            end
        end
        return m;
    endfunction

    function automatic logic [MAX_OUT_BITS-1:0] out_mask(input logic [WIDTH_REG_W-1:0] w);
        logic [MAX_OUT_BITS-1:0] m;
        m = '0;
        for (int i = 0; i < MAX_OUT_BITS; i++)
        begin
            if ((i == 0) || (i < int'(w)))
            begin
                m[i] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage

>>> rtl/core/ptg_if.sv
// Valid/ready channel interfaces of the probabilistic table gate: command,
// result and configuration write. Depends on ptg_pkg.
interface ptg_cmd_if import ptg_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic                    command;
    logic [MAX_IN_BITS-1:0]  in_pattern;
    logic [RND_W-1:0]        random_word;
    logic [MAX_IN_BITS-1:0]  write_row;
    logic [MAX_OUT_BITS-1:0] write_column;
    logic [WEIGHT_W-1:0]     write_weight;

    modport source (output valid, command, in_pattern, random_word, write_row,
                    write_column, write_weight, input ready);
    modport sink   (input valid, command, in_pattern, random_word, write_row,
                    write_column, write_weight, output ready);
endinterface

interface ptg_rsp_if import ptg_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [MAX_OUT_BITS-1:0] out_pattern;
    logic                    sum_error;

    modport source (output valid, out_pattern, sum_error, input ready);
    modport sink   (input valid, out_pattern, sum_error, output ready);
endinterface

interface ptg_cfg_if import ptg_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [WIDTH_REG_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/ptg_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Holds the weight table. Depends on nothing.
module ptg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/ptg_sub.sv
// Shared subtract-and-compare unit, used for the remainder steps and the
// row walk. Depends on ptg_pkg.
module ptg_sub import ptg_pkg::*; (
    input  sub_req_t req,
    output sub_rsp_t rsp
);

    always_comb
    begin
        {rsp.borrow, rsp.diff} = {1'b0, req.a} - {2'b00, req.b};
    end

endmodule

>>> rtl/core/ptg_seq.sv
// Sequencer of the probabilistic table gate: configuration registers, row
// sums, weight valid bits, remainder and walk control, result register.
// Depends on ptg_pkg and ptg_if; drives ptg_ram and ptg_sub.
module ptg_seq import ptg_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    ptg_cmd_if.sink            cmd_ch,
    ptg_rsp_if.source          rsp_ch,
    ptg_cfg_if.sink            cfg_ch,
    output logic               ram_we,
    output logic [ADDR_W-1:0]  ram_waddr,
    output logic [WEIGHT_W-1:0] ram_wdata,
    output logic [ADDR_W-1:0]  ram_raddr,
    input  logic [WEIGHT_W-1:0] ram_rdata,
    output sub_req_t           sub_req,
    input  sub_rsp_t           sub_rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WR_UPD,
        S_EV_DIV,
        S_EV_RD,
        S_EV_WALK,
        S_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [WIDTH_REG_W-1:0]  in_width_reg, in_width_next;
    logic [WIDTH_REG_W-1:0]  out_width_reg, out_width_next;
    logic [ENTRIES-1:0]      wvalid_reg;
    logic [SUM_W-1:0]        row_sum_reg [ROWS];
    logic [MAX_IN_BITS-1:0]  row_reg, row_next;
    logic [MAX_OUT_BITS-1:0] col_reg, col_next;
    logic [WEIGHT_W-1:0]     wr_weight_reg, wr_weight_next;
    logic [SUM_W-1:0]        divisor_reg, divisor_next;
    logic [SUM_W-1:0]        rem_reg, rem_next;
    logic [RND_W-1:0]        rnd_reg, rnd_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    err_reg, err_next;
    logic                    rd_vld_reg, rd_vld_next;
    logic                    out_valid_reg, out_valid_next;
    logic [MAX_OUT_BITS-1:0] out_pat_reg, out_pat_next;
    logic                    out_err_reg, out_err_next;

    logic                    accept;
    logic [MAX_IN_BITS-1:0]  eval_row;
    logic [MAX_IN_BITS-1:0]  rs_addr;
    logic [SUM_W-1:0]        rs_rdata;
    logic [SUM_W-1:0]        rs_wdata;
    logic [WEIGHT_W-1:0]     weight;
    logic [MAX_OUT_BITS-1:0] col_inc;
    logic [SUM_W-1:0]        rem_step;
    logic                    walk_gt;
    logic                    walk_last;

    assign accept    = cmd_ch.valid && cmd_ch.ready;
    assign eval_row  = cmd_ch.in_pattern & in_mask(in_width_reg);
    assign rs_addr   = (state_reg == S_IDLE) ? eval_row : row_reg;
    assign rs_rdata  = row_sum_reg[rs_addr];
    assign weight    = rd_vld_reg ? ram_rdata : '0;
    assign col_inc   = col_reg + 1'b1;
    assign rs_wdata  = rs_rdata - SUM_W'(weight) + SUM_W'(wr_weight_reg);
    assign walk_last = (col_reg == out_mask(out_width_reg));
    assign walk_gt   = !sub_rsp.borrow && (sub_rsp.diff != '0);

    // A trial that borrows keeps the shifted-in value, which is below the divisor.
    assign rem_step  = sub_rsp.borrow ? sub_req.a[SUM_W-1:0] : sub_rsp.diff[SUM_W-1:0];

    assign cmd_ch.ready       = (state_reg == S_IDLE);
    assign cfg_ch.ready       = 1'b1;
    assign rsp_ch.valid       = out_valid_reg;
    assign rsp_ch.out_pattern = out_pat_reg;
    assign rsp_ch.sum_error   = out_err_reg;

    assign ram_we    = (state_reg == S_WR_UPD);
    assign ram_waddr = {row_reg, col_reg};
    assign ram_wdata = wr_weight_reg;

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:    ram_raddr = {cmd_ch.write_row, cmd_ch.write_column};
            S_EV_WALK: ram_raddr = {row_reg, col_inc};
            default:   ram_raddr = {row_reg, col_reg};
        endcase
    end

    assign rd_vld_next = wvalid_reg[ram_raddr];

    always_comb
    begin
        if (state_reg == S_EV_DIV)
        begin
            sub_req.a = {rem_reg, rnd_reg[RND_W-1]};
            sub_req.b = divisor_reg;
        end
        else
        begin
            sub_req.a = {1'b0, rem_reg};
            sub_req.b = SUM_W'(weight);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        in_width_next  = in_width_reg;
        out_width_next = out_width_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        wr_weight_next = wr_weight_reg;
        divisor_next   = divisor_reg;
        rem_next       = rem_reg;
        rnd_next       = rnd_reg;
        cnt_next       = cnt_reg;
        err_next       = err_reg;
        out_pat_next   = out_pat_reg;
        out_err_next   = out_err_reg;
        out_valid_next = out_valid_reg && !rsp_ch.ready;

        if (cfg_ch.valid && cfg_ch.ready)
        begin
            unique case (cfg_ch.index)
                REG_IN_WIDTH:  in_width_next  = cfg_ch.data;
                REG_OUT_WIDTH: out_width_next = cfg_ch.data;
                default:       ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd_ch.command == CMD_WRITE)
                    begin
                        row_next       = cmd_ch.write_row;
                        col_next       = cmd_ch.write_column;
                        wr_weight_next = cmd_ch.write_weight;
                        state_next     = S_WR_UPD;
                    end
                    else
                    begin
                        row_next = eval_row;
                        col_next = '0;
                        if (rs_rdata < SUM_W'(2))
                        begin
                            err_next   = 1'b1;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            err_next     = 1'b0;
                            divisor_next = rs_rdata - 1'b1;
                            rem_next     = '0;
                            rnd_next     = cmd_ch.random_word;
                            cnt_next     = CNT_W'(RND_W - 1);
                            state_next   = S_EV_DIV;
                        end
                    end
                end
            end
            S_WR_UPD:
            begin
                state_next = S_IDLE;
            end
            S_EV_DIV:
            begin
                rnd_next = {rnd_reg[RND_W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    // The draw is one above the remainder.
                    rem_next   = rem_step + 1'b1;
                    state_next = S_EV_RD;
                end
                else
                begin
                    rem_next = rem_step;
                end
            end
            S_EV_RD:
            begin
                state_next = S_EV_WALK;
            end
            S_EV_WALK:
            begin
                // The next column is read ahead while the current one is compared.
                if (walk_gt && !walk_last)
                begin
                    rem_next = sub_rsp.diff[SUM_W-1:0];
                    col_next = col_inc;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp_ch.ready)
                begin
                    out_pat_next   = col_reg;
                    out_err_next   = err_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_width_reg  <= WIDTH_REG_W'(1);
            out_width_reg <= WIDTH_REG_W'(1);
            wvalid_reg    <= '0;
            for (int i = 0; i < ROWS; i++)
            begin
                row_sum_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
            rd_vld_reg    <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
            wr_weight_reg <= '0;
            divisor_reg   <= '0;
            rem_reg       <= '0;
            rnd_reg       <= '0;
            cnt_reg       <= '0;
            err_reg       <= 1'b0;
            out_pat_reg   <= '0;
            out_err_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_width_reg  <= in_width_next;
            out_width_reg <= out_width_next;
            out_valid_reg <= out_valid_next;
            rd_vld_reg    <= rd_vld_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            wr_weight_reg <= wr_weight_next;
            divisor_reg   <= divisor_next;
            rem_reg       <= rem_next;
            rnd_reg       <= rnd_next;
            cnt_reg       <= cnt_next;
            err_reg       <= err_next;
            out_pat_reg   <= out_pat_next;
            out_err_reg   <= out_err_next;
            if (state_reg == S_WR_UPD)
            begin
                wvalid_reg[ram_waddr] <= 1'b1;
                row_sum_reg[rs_addr]  <= rs_wdata;
            end
        end
    end

endmodule

>>> rtl/core/probabilistic_table_gate_top.sv
// Top level of the probabilistic table gate.
// Depends on ptg_pkg, ptg_if, ptg_ram, ptg_sub and ptg_seq.
//
// Usage:
// cmd_ch carries one command transaction at a time. A write command stores one
// weight of the table and updates the running sum of its row; it yields no
// result transaction and the block is idle again after the write-update state.
// An evaluate command selects a row from the low in_width bits of in_pattern,
// draws r = 1 + random_word mod (row sum - 1) and walks the row's weights.
// The remainder is formed one dividend bit per cycle on the shared subtractor,
// and the walk visits one to 2^w columns (w is out_width taken as one to four),
// fed by the weight RAM's registered read port. An evaluation runs the divide, read,
// walk and done states; a row sum below two goes straight to done and returns
// column 0 with sum_error set. cmd_ch.ready is high only while the sequencer is
// idle. Results sit in an output register, so a new command is taken while an
// earlier result waits; a finished evaluation holds until that register is free.
// cfg_ch is always ready; it is to be written while idle, which the block
// does not enforce. Reset sets both widths to one and marks every weight invalid,
// so the table and the row sums read as zero without a clearing pass.
module probabilistic_table_gate_top import ptg_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    ptg_cmd_if.sink   cmd_ch,
    ptg_rsp_if.source rsp_ch,
    ptg_cfg_if.sink   cfg_ch
);

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [WEIGHT_W-1:0] ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [WEIGHT_W-1:0] ram_rdata;
    sub_req_t            sub_req;
    sub_rsp_t            sub_rsp;

    ptg_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (ENTRIES)
    ) u_weights (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ptg_sub u_sub (
        .req (sub_req),
        .rsp (sub_rsp)
    );

    ptg_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_ch    (cmd_ch),
        .rsp_ch    (rsp_ch),
        .cfg_ch    (cfg_ch),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .sub_req   (sub_req),
        .sub_rsp   (sub_rsp)
    );

    // A failed draw always reports column zero.
    a_err_col_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_ch.valid && rsp_ch.sum_error |-> rsp_ch.out_pattern == '0)
        else $error("sum_error result with nonzero out_pattern");

    // Every command leaves the sequencer busy in the cycle after it is taken.
    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ch.valid && cmd_ch.ready |=> !cmd_ch.ready)
        else $error("command channel ready right after a taken command");

    // A new result is only loaded by a busy sequencer.
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_ch.valid) |-> $past(!cmd_ch.ready))
        else $error("result appeared while the sequencer was idle");

    // Weights are only written during a write update, never while ready.
    a_write_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !cmd_ch.ready)
        else $error("weight write while the sequencer was idle");

endmodule
